// ----- design/ppq_pkg.sv -----
// ----------------------------------------------------------------------------
// ppq_pkg
// request and response types and operation codes for the process pool
// priority queue
// ----------------------------------------------------------------------------
package ppq_pkg;

    localparam int ID_W   = 4;
    localparam int PRIO_W = 8;

    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_ENQUEUE = 2'd2;
    localparam logic [1:0] MODE_DEQUEUE = 2'd3;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ID_W-1:0]   entry_id;
        logic [PRIO_W-1:0] priority_req;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0] result_id;
        logic            result_valid;
    } t_rsp;

endpackage

// ----- design/ppq_tables.sv -----
// ----------------------------------------------------------------------------
// ppq_tables
// shared link table and priority table, one registered read port and one
// write port; unwritten entries read as their reset values
// ----------------------------------------------------------------------------
module ppq_tables #(
    parameter int NUM_ENTRIES    = 16,
    parameter int PRIORITY_WIDTH = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_rd_en,
    input  logic [$clog2(NUM_ENTRIES)-1:0]        i_rd_addr,
    output logic [$clog2(NUM_ENTRIES+1)-1:0]      o_rd_link,
    output logic [PRIORITY_WIDTH-1:0]             o_rd_prio,
    input  logic [$clog2(NUM_ENTRIES)-1:0]        i_wr_addr,
    input  logic                                  i_wr_link_en,
    input  logic [$clog2(NUM_ENTRIES+1)-1:0]      i_wr_link,
    input  logic                                  i_wr_prio_en,
    input  logic [PRIORITY_WIDTH-1:0]             i_wr_prio
);
    import ppq_pkg::*;

    localparam int IW = $clog2(NUM_ENTRIES);
    localparam int LW = $clog2(NUM_ENTRIES + 1);

    logic [LW-1:0]             r_link_mem [NUM_ENTRIES];
    logic [PRIORITY_WIDTH-1:0] r_prio_mem [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0]    r_link_vld;
    logic [NUM_ENTRIES-1:0]    r_prio_vld;

    logic [LW-1:0]             r_rd_link;
    logic [PRIORITY_WIDTH-1:0] r_rd_prio;
    logic [IW-1:0]             r_rd_idx;
    logic                      r_rd_link_vld;
    logic                      r_rd_prio_vld;

    // storage arrays and read data
    always_ff @(posedge i_clk) begin
        if (i_wr_link_en) begin
            r_link_mem[i_wr_addr] <= i_wr_link;
        end
        if (i_wr_prio_en) begin
            r_prio_mem[i_wr_addr] <= i_wr_prio;
        end
        if (i_rd_en) begin
            r_rd_link     <= r_link_mem[i_rd_addr];
            r_rd_prio     <= r_prio_mem[i_rd_addr];
            r_rd_idx      <= i_rd_addr;
            r_rd_link_vld <= r_link_vld[i_rd_addr];
            r_rd_prio_vld <= r_prio_vld[i_rd_addr];
        end
    end

    // written flags, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_vld <= '0;
            r_prio_vld <= '0;
        end else begin
            if (i_wr_link_en) begin
                r_link_vld[i_wr_addr] <= 1'b1;
            end
            if (i_wr_prio_en) begin
                r_prio_vld[i_wr_addr] <= 1'b1;
            end
        end
    end

    // reset contents: each id links to the next, priorities zero
    assign o_rd_link = r_rd_link_vld ? r_rd_link : (LW'(r_rd_idx) + LW'(1));
    assign o_rd_prio = r_rd_prio_vld ? r_rd_prio : '0;

endmodule

// ----- design/process_pool_priority_queue.sv -----
// ----------------------------------------------------------------------------
// process_pool_priority_queue
// pool of slot ids with a lifo free list and a priority ordered ready queue
// sharing one link table
// ----------------------------------------------------------------------------
// one request is handled at a time and o_req_stall stays high until its
// response has been formed. allocate and dequeue do one table read, none
// when the list is empty; release and enqueue into an empty queue do no
// read, enqueue at the head reads the head, and an enqueue past the head
// then reads one entry per walk step, at most NUM_ENTRIES steps; the single
// read port of the link/priority tables is visited once per link.
// a finished response is held in an output register, so a new request is
// taken while the previous response still waits under i_rsp_stall. there is
// no clearing pass after reset: per-entry written flags make unwritten
// entries read as their reset values.
module process_pool_priority_queue #(
    parameter int NUM_ENTRIES    = 16,
    parameter int PRIORITY_WIDTH = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  ppq_pkg::t_req i_req,
    output logic          o_req_stall,
    output logic          o_rsp_valid,
    output ppq_pkg::t_rsp o_rsp,
    input  logic          i_rsp_stall
);
    import ppq_pkg::*;

    localparam int IW = $clog2(NUM_ENTRIES);
    localparam int LW = $clog2(NUM_ENTRIES + 1);
    localparam logic [LW-1:0] NULL_ID = LW'(NUM_ENTRIES);

    // sequencer states
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_POP       = 4'd1;
    localparam logic [3:0] S_ENQ_START = 4'd2;
    localparam logic [3:0] S_ENQ_HEAD  = 4'd3;
    localparam logic [3:0] S_WALK      = 4'd4;
    localparam logic [3:0] S_EVAL      = 4'd5;
    localparam logic [3:0] S_INS_ID    = 4'd6;
    localparam logic [3:0] S_INS_PREV  = 4'd7;
    localparam logic [3:0] S_DONE      = 4'd8;
    localparam logic [3:0] S_HEAD_EVAL = 4'd9;

    logic [3:0]                r_state, n_state;
    logic [1:0]                r_mode, n_mode;
    logic [IW-1:0]             r_id, n_id;
    logic [PRIORITY_WIDTH-1:0] r_prio, n_prio;
    logic [LW-1:0]             r_q, n_q;          // walk position / popped head
    logic [LW-1:0]             r_n, n_n;          // link of r_q
    logic [LW-1:0]             r_steps, n_steps;
    logic [LW-1:0]             r_free_head, n_free_head;
    logic [LW-1:0]             r_ready_head, n_ready_head;
    t_rsp                      r_res, n_res;
    logic                      r_rsp_valid, n_rsp_valid;
    t_rsp                      r_rsp, n_rsp;

    // table port
    logic                      rd_en;
    logic [IW-1:0]             rd_addr;
    logic [LW-1:0]             rd_link;
    logic [PRIORITY_WIDTH-1:0] rd_prio;
    logic [IW-1:0]             wr_addr;
    logic                      wr_link_en;
    logic [LW-1:0]             wr_link;
    logic                      wr_prio_en;

    logic req_acc;
    logic id_ok;
    logic rsp_free;
    logic [LW-1:0] pop_head;

    ppq_tables #(
        .NUM_ENTRIES    (NUM_ENTRIES),
        .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_tables (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_en      (rd_en),
        .i_rd_addr    (rd_addr),
        .o_rd_link    (rd_link),
        .o_rd_prio    (rd_prio),
        .i_wr_addr    (wr_addr),
        .i_wr_link_en (wr_link_en),
        .i_wr_link    (wr_link),
        .i_wr_prio_en (wr_prio_en),
        .i_wr_prio    (r_prio)
    );

    // requests are only taken while the sequencer is idle
    assign o_req_stall = (r_state != S_IDLE);
    assign req_acc     = i_req_valid && !o_req_stall;
    assign rsp_free    = !r_rsp_valid || !i_rsp_stall;

    // ids above the table are ignored for release and enqueue
    assign id_ok    = (32'(i_req.entry_id) < NUM_ENTRIES);
    assign pop_head = (i_req.mode == MODE_ALLOC) ? r_free_head : r_ready_head;

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_id         = r_id;
        n_prio       = r_prio;
        n_q          = r_q;
        n_n          = r_n;
        n_steps      = r_steps;
        n_free_head  = r_free_head;
        n_ready_head = r_ready_head;
        n_res        = r_res;
        n_rsp_valid  = r_rsp_valid;
        n_rsp        = r_rsp;
        rd_en        = 1'b0;
        rd_addr      = r_n[IW-1:0];
        wr_addr      = r_id;
        wr_link_en   = 1'b0;
        wr_link      = r_n;
        wr_prio_en   = 1'b0;

        // output register drains independently of the sequencer
        if (r_rsp_valid && !i_rsp_stall) begin
            n_rsp_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_mode = i_req.mode;
                    n_id   = IW'(i_req.entry_id);
                    n_prio = PRIORITY_WIDTH'(i_req.priority_req);
                    case (i_req.mode)
                        MODE_ALLOC, MODE_DEQUEUE: begin
                            n_q = pop_head;
                            if (pop_head != NULL_ID) begin
                                // fetch the link of the head being popped
                                rd_en   = 1'b1;
                                rd_addr = pop_head[IW-1:0];
                                n_state = S_POP;
                            end else begin
                                n_res   = '{result_id: '0, result_valid: 1'b0};
                                n_state = S_DONE;
                            end
                        end
                        MODE_RELEASE: begin
                            n_res = '{result_id: i_req.entry_id, result_valid: id_ok};
                            if (id_ok) begin
                                // push onto the free list
                                wr_addr     = IW'(i_req.entry_id);
                                wr_link_en  = 1'b1;
                                wr_link     = r_free_head;
                                n_free_head = LW'(i_req.entry_id);
                            end
                            n_state = S_DONE;
                        end
                        default: begin
                            n_res = '{result_id: i_req.entry_id, result_valid: id_ok};
                            n_state = id_ok ? S_ENQ_START : S_DONE;
                        end
                    endcase
                end
            end

            S_POP: begin
                if (r_mode == MODE_ALLOC) begin
                    n_free_head = rd_link;
                end else begin
                    n_ready_head = rd_link;
                end
                n_res   = '{result_id: ID_W'(r_q), result_valid: 1'b1};
                n_state = S_DONE;
            end

            S_ENQ_START: begin
                // priority is stored before any compare so a requeued id sees it
                wr_prio_en = 1'b1;
                n_q        = r_ready_head;
                if (r_ready_head == NULL_ID) begin
                    wr_link_en   = 1'b1;
                    wr_link      = NULL_ID;
                    n_ready_head = LW'(r_id);
                    n_state      = S_DONE;
                end else begin
                    n_state = S_ENQ_HEAD;
                end
            end

            S_ENQ_HEAD: begin
                // read issued in the cycle after the priority write
                rd_en   = 1'b1;
                rd_addr = r_q[IW-1:0];
                n_steps = '0;
                n_state = S_HEAD_EVAL;
            end

            S_HEAD_EVAL: begin
                // shared compare: new priority against the current head
                if (r_prio > rd_prio) begin
                    // beats the head: becomes the new head
                    wr_link_en   = 1'b1;
                    wr_link      = r_q;
                    n_ready_head = LW'(r_id);
                    n_state      = S_DONE;
                end else begin
                    n_n     = rd_link;
                    n_state = S_WALK;
                end
            end

            S_WALK: begin
                if (r_steps == LW'(NUM_ENTRIES) || r_n == NULL_ID) begin
                    n_state = S_INS_ID;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_n[IW-1:0];
                    n_state = S_EVAL;
                end
            end

            S_EVAL: begin
                // shared compare: new priority against the entry at r_n
                if (r_prio > rd_prio) begin
                    n_state = S_INS_ID;
                end else begin
                    n_steps = r_steps + LW'(1);
                    n_q     = r_n;
                    n_n     = rd_link;
                    n_state = S_WALK;
                end
            end

            S_INS_ID: begin
                wr_link_en = 1'b1;
                wr_link    = r_n;
                n_state    = S_INS_PREV;
            end

            S_INS_PREV: begin
                wr_addr    = r_q[IW-1:0];
                wr_link_en = 1'b1;
                wr_link    = LW'(r_id);
                n_state    = S_DONE;
            end

            S_DONE: begin
                if (rsp_free) begin
                    n_rsp_valid = 1'b1;
                    n_rsp       = r_res;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_free_head  <= '0;
            r_ready_head <= NULL_ID;
            r_rsp_valid  <= 1'b0;
            r_steps      <= '0;
        end else begin
            r_state      <= n_state;
            r_free_head  <= n_free_head;
            r_ready_head <= n_ready_head;
            r_rsp_valid  <= n_rsp_valid;
            r_steps      <= n_steps;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_id   <= n_id;
        r_prio <= n_prio;
        r_q    <= n_q;
        r_n    <= n_n;
        r_res  <= n_res;
        r_rsp  <= n_rsp;
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

`ifndef ASSERT_OFF
    // list heads never hold a value beyond the null marker
    a_heads_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free_head <= NULL_ID) && (r_ready_head <= NULL_ID))
        else $error("list head beyond null marker");

    // the walk is bounded by the table size
    a_steps_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps <= LW'(NUM_ENTRIES))
        else $error("enqueue walk exceeded table size");

    // allocate from an empty free list goes straight to the response
    a_empty_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && i_req.mode == MODE_ALLOC && r_free_head == NULL_ID)
        |=> (r_state == S_DONE && !r_res.result_valid))
        else $error("empty allocate not answered at once");

    // a new response only appears out of the done state
    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_rsp_valid || !i_rsp_stall) ##1 r_rsp_valid |-> $past(r_state) == S_DONE)
        else $error("response loaded outside done state");
`endif

endmodule
